// ===== src/affine_warp_bilinear_normalize_core_defines.svh =====
// Assertion macros shared by the warp core.
`ifndef AFFINE_WARP_BILINEAR_NORMALIZE_CORE_DEFINES_SVH
`define AFFINE_WARP_BILINEAR_NORMALIZE_CORE_DEFINES_SVH

// Same-cycle implication.
`define AWBN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AWBN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/awbn_pkg.sv =====
`timescale 1ns / 1ps
package awbn_pkg;

    localparam int DEF_MAX_IMG_W = 256;
    localparam int DEF_MAX_IMG_H = 256;
    localparam int DEF_OUT_W     = 112;
    localparam int DEF_OUT_H     = 112;

    localparam int COEF_W = 32;
    localparam int PROD_W = 40;
    localparam int SUM_W  = 42;
    localparam int IP_W   = 26;
    localparam int FR_W   = 17;
    localparam int WGT_W  = 19;
    localparam int SMP_W  = 10;
    localparam int H_W    = 29;
    localparam int V2_W   = 48;
    localparam int T_W    = 22;
    localparam int RCP_W  = 17;
    localparam int QE_W   = 15;
    localparam int NORM_W = 16;
    localparam int DIM_W  = 14;
    localparam int PIX_W  = 24;

    localparam logic [2:0] REG_INV_XX  = 3'd0;
    localparam logic [2:0] REG_INV_XY  = 3'd1;
    localparam logic [2:0] REG_INV_XO  = 3'd2;
    localparam logic [2:0] REG_INV_YX  = 3'd3;
    localparam logic [2:0] REG_INV_YY  = 3'd4;
    localparam logic [2:0] REG_INV_YO  = 3'd5;
    localparam logic [2:0] REG_IMG_W   = 3'd6;
    localparam logic [2:0] REG_IMG_H   = 3'd7;

    localparam logic signed [COEF_W-1:0] Q16_ONE = 32'sd65536;
    localparam logic [8:0] IMG_DIM_RST = 9'd256;

    // doubled mid-grey
    localparam logic [SMP_W-1:0] GREY2 = 10'd255;

    // 255 * 2^32, rounding offset 255 * 2^17, saturation threshold 255 * 16385
    localparam logic [V2_W:0] NORM_DEN = 49'd1095216660480;
    localparam logic [V2_W+1:0] NORM_RND = 50'd33423360;
    localparam logic [31:0] NORM_SAT_T = 32'd4178175;
    localparam logic [RCP_W-1:0] RECIP_255 = 17'd65793;
    localparam logic [QE_W-1:0] Q_MAX = 15'd16384;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_bank;
        logic [3:0] rd_en;
    } t_mem_ctl;

endpackage

// ===== src/awbn_frame_mem.sv =====
`timescale 1ns / 1ps
module awbn_frame_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                              i_clk,
    input  awbn_pkg::t_mem_ctl                i_ctl,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [awbn_pkg::PIX_W-1:0]        i_wr_data,
    input  logic [3:0][AW-1:0]                i_rd_addr,
    output logic [3:0][awbn_pkg::PIX_W-1:0]   o_rd_data
);

    // bank index = {row parity, column parity}
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [awbn_pkg::PIX_W-1:0] r_mem [DEPTH];
        logic [awbn_pkg::PIX_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_ctl.wr_en && i_ctl.wr_bank == 2'(b)) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_ctl.rd_en[b]) begin
                r_rd <= r_mem[i_rd_addr[b]];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

// ===== src/awbn_norm.sv =====
`timescale 1ns / 1ps
module awbn_norm (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [awbn_pkg::V2_W-1:0]         i_v2 [3],
    output logic                                     o_valid,
    output logic signed [awbn_pkg::NORM_W-1:0]       o_norm [3]
);

    logic                          r_v1, r_v2, r_v3;
    logic [awbn_pkg::T_W-1:0]      r_t1 [3];
    logic                          r_sat1 [3];
    logic                          r_neg1 [3];
    logic [awbn_pkg::T_W-1:0]      r_t2 [3];
    logic                          r_sat2 [3];
    logic                          r_neg2 [3];
    logic [awbn_pkg::T_W+awbn_pkg::RCP_W-1:0] r_prod [3];
    logic signed [awbn_pkg::NORM_W-1:0] r_out [3];

    logic signed [awbn_pkg::V2_W:0] d [3];
    logic [awbn_pkg::V2_W:0]        mag [3];
    logic [awbn_pkg::V2_W+1:0]      rnd [3];
    logic [31:0]                    t_full [3];
    logic [awbn_pkg::QE_W-1:0]      qe [3];
    logic [awbn_pkg::T_W:0]         rem [3];
    logic [awbn_pkg::QE_W-1:0]      q [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d[c]      = {i_v2[c][awbn_pkg::V2_W-1], i_v2[c]} - $signed(awbn_pkg::NORM_DEN);
            mag[c]    = d[c][awbn_pkg::V2_W] ? 49'(-d[c]) : 49'(d[c]);
            rnd[c]    = {1'b0, mag[c]} + awbn_pkg::NORM_RND;
            t_full[c] = 32'(rnd[c] >> 18);
            qe[c]     = r_prod[c][awbn_pkg::T_W+awbn_pkg::RCP_W-1 -: awbn_pkg::QE_W];
            rem[c]    = {1'b0, r_t2[c]} - (23'({qe[c], 8'b0}) - 23'(qe[c]));
            if (r_sat2[c]) begin
                q[c] = awbn_pkg::Q_MAX;
            end else if (rem[c] >= 23'd255) begin
                q[c] = qe[c] + 15'd1;
            end else begin
                q[c] = qe[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_t1[c]   <= t_full[c][awbn_pkg::T_W-1:0];
            r_sat1[c] <= t_full[c] >= awbn_pkg::NORM_SAT_T;
            r_neg1[c] <= d[c][awbn_pkg::V2_W];
            r_t2[c]   <= r_t1[c];
            r_sat2[c] <= r_sat1[c];
            r_neg2[c] <= r_neg1[c];
            r_prod[c] <= 39'(r_t1[c]) * 39'(awbn_pkg::RECIP_255);
            r_out[c]  <= r_neg2[c] ? -$signed({1'b0, q[c]}) : $signed({1'b0, q[c]});
        end
    end

    assign o_valid = r_v3;
    assign o_norm  = r_out;

endmodule

// ===== src/affine_warp_bilinear_normalize_core.sv =====
`timescale 1ns / 1ps
`include "affine_warp_bilinear_normalize_core_defines.svh"
// Affine warp with bilinear sampling and (v-127.5)/127.5 normalization.
// Command channel: an item is taken when start is high and busy is low.
// busy never rises, so one item can enter every cycle. i_kind = 0 writes
// pixel (i_src_col, i_src_row); i_kind = 1 requests output pixel
// (i_dst_col, i_dst_row). A request inside the output frame returns one
// word on o_norm_ch0..2, marked by o_valid for one cycle. Writes and
// out-of-frame requests return nothing. Results come out in request
// order, one per cycle at most. The receiver has no stall; it must take
// each word when o_valid is high. The frame lives in four RAM banks split
// by row and column parity, so the four neighbours of a sample are read
// in the same cycle; this sets the rate of one item per cycle. Writes pass
// down the same pipeline and hit the banks in the same stage as reads,
// which keeps read-after-write order. Coefficients and image size are set
// through the APB port; the user must write them only while the block is
// idle, which the block does not enforce. Reset restores the identity
// mapping and a 256x256 image; frame contents are undefined until written.
module affine_warp_bilinear_normalize_core #(
    parameter int MAX_IMG_W = awbn_pkg::DEF_MAX_IMG_W,
    parameter int MAX_IMG_H = awbn_pkg::DEF_MAX_IMG_H,
    parameter int OUT_W     = awbn_pkg::DEF_OUT_W,
    parameter int OUT_H     = awbn_pkg::DEF_OUT_H
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [7:0]         i_src_col,
    input  logic [7:0]         i_src_row,
    input  logic [7:0]         i_red_in,
    input  logic [7:0]         i_green_in,
    input  logic [7:0]         i_blue_in,
    input  logic [6:0]         i_dst_col,
    input  logic [6:0]         i_dst_row,
    output logic               o_valid,
    output logic signed [15:0] o_norm_ch0,
    output logic signed [15:0] o_norm_ch1,
    output logic signed [15:0] o_norm_ch2,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int BW    = (MAX_IMG_W + 1) / 2;
    localparam int BH    = (MAX_IMG_H + 1) / 2;
    localparam int DEPTH = BW * BH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CW = awbn_pkg::COEF_W;
    localparam int PW = awbn_pkg::PROD_W;
    localparam int SW = awbn_pkg::SUM_W;
    localparam int IW = awbn_pkg::IP_W;
    localparam int FW = awbn_pkg::FR_W;
    localparam int GW = awbn_pkg::WGT_W;
    localparam int MW = awbn_pkg::SMP_W;
    localparam int HW = awbn_pkg::H_W;
    localparam int VW = awbn_pkg::V2_W;
    localparam int DW = awbn_pkg::DIM_W;
    localparam int XW = awbn_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] r_coef [6];
    logic [8:0]           r_img_w, r_img_h;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= awbn_pkg::Q16_ONE;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= awbn_pkg::Q16_ONE;
            r_coef[5] <= '0;
            r_img_w   <= awbn_pkg::IMG_DIM_RST;
            r_img_h   <= awbn_pkg::IMG_DIM_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                awbn_pkg::REG_INV_XX: r_coef[0] <= pwdata;
                awbn_pkg::REG_INV_XY: r_coef[1] <= pwdata;
                awbn_pkg::REG_INV_XO: r_coef[2] <= pwdata;
                awbn_pkg::REG_INV_YX: r_coef[3] <= pwdata;
                awbn_pkg::REG_INV_YY: r_coef[4] <= pwdata;
                awbn_pkg::REG_INV_YO: r_coef[5] <= pwdata;
                awbn_pkg::REG_IMG_W:  r_img_w   <= pwdata[8:0];
                awbn_pkg::REG_IMG_H:  r_img_h   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            awbn_pkg::REG_INV_XX: prdata = r_coef[0];
            awbn_pkg::REG_INV_XY: prdata = r_coef[1];
            awbn_pkg::REG_INV_XO: prdata = r_coef[2];
            awbn_pkg::REG_INV_YX: prdata = r_coef[3];
            awbn_pkg::REG_INV_YY: prdata = r_coef[4];
            awbn_pkg::REG_INV_YO: prdata = r_coef[5];
            awbn_pkg::REG_IMG_W:  prdata = {23'b0, r_img_w};
            awbn_pkg::REG_IMG_H:  prdata = {23'b0, r_img_h};
            default:              prdata = '0;
        endcase
    end

    // ---------------- stage 1: coefficient products ----------------
    logic acc;
    assign busy = 1'b0;
    assign acc  = start & ~busy;

    logic                 r_s1_smp, r_s1_wr;
    logic signed [PW-1:0] r_s1_p [4];
    logic [XW-1:0]        r_s1_wdata;
    logic [AW-1:0]        r_s1_waddr;
    logic [1:0]           r_s1_wbank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_smp <= 1'b0;
            r_s1_wr  <= 1'b0;
        end else begin
            r_s1_smp <= acc & i_kind & (int'(i_dst_col) < OUT_W) & (int'(i_dst_row) < OUT_H);
            r_s1_wr  <= acc & ~i_kind & (int'(i_src_col) < MAX_IMG_W)
                        & (int'(i_src_row) < MAX_IMG_H);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_p[0]  <= r_coef[0] * $signed({1'b0, i_dst_col});
        r_s1_p[1]  <= r_coef[1] * $signed({1'b0, i_dst_row});
        r_s1_p[2]  <= r_coef[3] * $signed({1'b0, i_dst_col});
        r_s1_p[3]  <= r_coef[4] * $signed({1'b0, i_dst_row});
        r_s1_wdata <= {i_blue_in, i_green_in, i_red_in};
        r_s1_waddr <= AW'(i_src_row >> 1) * AW'(BW) + AW'(i_src_col >> 1);
        r_s1_wbank <= {i_src_row[0], i_src_col[0]};
    end

    // ---------------- stage 2: source position ----------------
    logic                 r_s2_smp, r_s2_wr;
    logic signed [SW-1:0] r_s2_sx, r_s2_sy;
    logic [XW-1:0]        r_s2_wdata;
    logic [AW-1:0]        r_s2_waddr;
    logic [1:0]           r_s2_wbank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_smp <= 1'b0;
            r_s2_wr  <= 1'b0;
        end else begin
            r_s2_smp <= r_s1_smp;
            r_s2_wr  <= r_s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sx    <= SW'(r_s1_p[0]) + SW'(r_s1_p[1]) + SW'(r_coef[2]);
        r_s2_sy    <= SW'(r_s1_p[2]) + SW'(r_s1_p[3]) + SW'(r_coef[5]);
        r_s2_wdata <= r_s1_wdata;
        r_s2_waddr <= r_s1_waddr;
        r_s2_wbank <= r_s1_wbank;
    end

    // ---------------- stage 3: truncate toward zero ----------------
    logic [SW-1:0] mag_x, mag_y;
    logic [IW-1:0] ip_x, ip_y;
    logic [15:0]   fr_x, fr_y;

    always_comb begin
        mag_x = r_s2_sx[SW-1] ? SW'(-r_s2_sx) : SW'(r_s2_sx);
        mag_y = r_s2_sy[SW-1] ? SW'(-r_s2_sy) : SW'(r_s2_sy);
        ip_x  = mag_x[16 +: IW];
        ip_y  = mag_y[16 +: IW];
        fr_x  = mag_x[15:0];
        fr_y  = mag_y[15:0];
    end

    logic                 r_s3_smp, r_s3_wr;
    logic signed [IW-1:0] r_s3_x0, r_s3_y0;
    logic signed [FW-1:0] r_s3_fx, r_s3_fy;
    logic [XW-1:0]        r_s3_wdata;
    logic [AW-1:0]        r_s3_waddr;
    logic [1:0]           r_s3_wbank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_smp <= 1'b0;
            r_s3_wr  <= 1'b0;
        end else begin
            r_s3_smp <= r_s2_smp;
            r_s3_wr  <= r_s2_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_x0    <= r_s2_sx[SW-1] ? -$signed(ip_x) : $signed(ip_x);
        r_s3_y0    <= r_s2_sy[SW-1] ? -$signed(ip_y) : $signed(ip_y);
        r_s3_fx    <= r_s2_sx[SW-1] ? -$signed({1'b0, fr_x}) : $signed({1'b0, fr_x});
        r_s3_fy    <= r_s2_sy[SW-1] ? -$signed({1'b0, fr_y}) : $signed({1'b0, fr_y});
        r_s3_wdata <= r_s2_wdata;
        r_s3_waddr <= r_s2_waddr;
        r_s3_wbank <= r_s2_wbank;
    end

    // ---------------- memory access ----------------
    logic [DW-1:0]        w_use, h_use;
    logic signed [IW-1:0] w_s, h_s, x1, y1;
    logic [1:0]           in_x, in_y;
    logic [3:0]           inb;
    logic [AW-1:0]        col_i [2];
    logic [AW-1:0]        row_i [2];
    logic [3:0][AW-1:0]   rd_addr;
    logic [3:0][XW-1:0]   rd_data;
    awbn_pkg::t_mem_ctl   mem_ctl;

    always_comb begin
        w_use   = (int'(r_img_w) < MAX_IMG_W) ? DW'(r_img_w) : DW'(MAX_IMG_W);
        h_use   = (int'(r_img_h) < MAX_IMG_H) ? DW'(r_img_h) : DW'(MAX_IMG_H);
        w_s     = $signed(IW'(w_use));
        h_s     = $signed(IW'(h_use));
        x1      = r_s3_x0 + IW'(1);
        y1      = r_s3_y0 + IW'(1);
        in_x[0] = (r_s3_x0 >= 0) && (r_s3_x0 < w_s);
        in_x[1] = (x1 >= 0) && (x1 < w_s);
        in_y[0] = (r_s3_y0 >= 0) && (r_s3_y0 < h_s);
        in_y[1] = (y1 >= 0) && (y1 < h_s);
        for (int n = 0; n < 4; n++) begin
            inb[n] = in_x[n % 2] & in_y[n / 2];
        end
        // even column/row in the pair is x0 or x0+1; odd one is x0>>1 either way
        col_i[0] = AW'(r_s3_x0 >>> 1) + AW'(r_s3_x0[0]);
        col_i[1] = AW'(r_s3_x0 >>> 1);
        row_i[0] = AW'(r_s3_y0 >>> 1) + AW'(r_s3_y0[0]);
        row_i[1] = AW'(r_s3_y0 >>> 1);
        mem_ctl.wr_en   = r_s3_wr;
        mem_ctl.wr_bank = r_s3_wbank;
        for (int b = 0; b < 4; b++) begin
            rd_addr[b]       = row_i[b / 2] * AW'(BW) + col_i[b % 2];
            mem_ctl.rd_en[b] = r_s3_smp
                & inb[{1'(b / 2) ^ r_s3_y0[0], 1'(b % 2) ^ r_s3_x0[0]}];
        end
    end

    awbn_frame_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_wr_addr(r_s3_waddr),
        .i_wr_data(r_s3_wdata),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // ---------------- stage 4: horizontal blend ----------------
    logic                 r_s4_smp;
    logic                 r_s4_xp, r_s4_yp;
    logic [3:0]           r_s4_inb;
    logic signed [FW-1:0] r_s4_fx, r_s4_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_smp <= 1'b0;
        end else begin
            r_s4_smp <= r_s3_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_xp  <= r_s3_x0[0];
        r_s4_yp  <= r_s3_y0[0];
        r_s4_inb <= inb;
        r_s4_fx  <= r_s3_fx;
        r_s4_fy  <= r_s3_fy;
    end

    logic [MW-1:0]        smp [4][3];
    logic signed [GW-1:0] wx0, fx_e;
    logic [1:0]           bk;

    always_comb begin
        fx_e = GW'(r_s4_fx);
        wx0  = GW'(awbn_pkg::Q16_ONE) - fx_e;
        for (int n = 0; n < 4; n++) begin
            bk = {1'(n / 2) ^ r_s4_yp, 1'(n % 2) ^ r_s4_xp};
            for (int c = 0; c < 3; c++) begin
                smp[n][c] = r_s4_inb[n] ? {1'b0, rd_data[bk][8*c +: 8], 1'b0}
                                        : awbn_pkg::GREY2;
            end
        end
    end

    logic                 r_s5_smp;
    logic signed [HW-1:0] r_s5_h0 [3];
    logic signed [HW-1:0] r_s5_h1 [3];
    logic signed [FW-1:0] r_s5_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_smp <= 1'b0;
        end else begin
            r_s5_smp <= r_s4_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_s5_h0[c] <= $signed(smp[0][c]) * wx0 + $signed(smp[1][c]) * fx_e;
            r_s5_h1[c] <= $signed(smp[2][c]) * wx0 + $signed(smp[3][c]) * fx_e;
        end
        r_s5_fy <= r_s4_fy;
    end

    // ---------------- stage 5: vertical blend ----------------
    logic signed [GW-1:0] wy0, fy_e;
    assign fy_e = GW'(r_s5_fy);
    assign wy0  = GW'(awbn_pkg::Q16_ONE) - fy_e;

    logic                 r_s6_smp;
    logic signed [VW-1:0] r_s6_v2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_smp <= 1'b0;
        end else begin
            r_s6_smp <= r_s5_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_s6_v2[c] <= r_s5_h0[c] * wy0 + r_s5_h1[c] * fy_e;
        end
    end

    // ---------------- normalize ----------------
    logic signed [awbn_pkg::NORM_W-1:0] norm [3];

    awbn_norm u_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s6_smp),
        .i_v2   (r_s6_v2),
        .o_valid(o_valid),
        .o_norm (norm)
    );

    assign o_norm_ch0 = norm[0];
    assign o_norm_ch1 = norm[1];
    assign o_norm_ch2 = norm[2];

    // ---------------- assertions ----------------
    `AWBN_ASSERT_IMP(a_wr_no_rd, i_clk, i_rst_n, mem_ctl.wr_en, mem_ctl.rd_en == 4'b0,
        "bank read and write issued for the same word")
    `AWBN_ASSERT_NEXT(a_wr_slot, i_clk, i_rst_n, mem_ctl.wr_en, !r_s4_smp,
        "sample found behind a write slot")
    `AWBN_ASSERT_IMP(a_out_src, i_clk, i_rst_n, o_valid,
        $past(start && !busy && i_kind, 9), "result without a sample request")
    `AWBN_ASSERT_IMP(a_out_rng, i_clk, i_rst_n, o_valid,
        (o_norm_ch0 >= -16'sd16384) && (o_norm_ch0 <= 16'sd16384)
        && (o_norm_ch1 >= -16'sd16384) && (o_norm_ch1 <= 16'sd16384)
        && (o_norm_ch2 >= -16'sd16384) && (o_norm_ch2 <= 16'sd16384),
        "normalized value outside Q1.14 range")

endmodule
